// File: rtl/core/string_to_signed_parser_assert.svh
// Assertion macros for the string_to_signed_parser block.
// Used by the top level only; needs clk and rst in the including scope.
`ifndef STRING_TO_SIGNED_PARSER_ASSERT_SVH
`define STRING_TO_SIGNED_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked on the same edge
`define SSP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("string_to_signed_parser assertion failed");
// Implication checked on the next edge
`define SSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("string_to_signed_parser assertion failed");
`else
`define SSP_ASSERT_IMPLY(label, ante, cons)
`define SSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/ssp_pkg.sv
// Shared types and constants for the string_to_signed_parser block.
// No dependencies; imported by ssp_decode, ssp_parse and the top level.
package ssp_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int IDX_W      = 13;
  localparam int BASE_W     = 6;
  localparam int MAG_W      = 32;
  localparam int PROD_W     = MAG_W + BASE_W;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0] NO_DIGIT   = '1;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_PREFIX = 3'd2,
    PH_AFTERX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_OVER   = 3'd5,
    PH_STOP   = 3'd6
  } phase_t;

  // Classification of one string byte
  typedef struct packed {
    logic              is_nul;
    logic              is_space;
    logic              is_plus;
    logic              is_minus;
    logic              is_zero;
    logic              is_x;
    logic [BASE_W-1:0] digit;
  } char_class_t;

  // Result of a string, valid at its zero byte
  typedef struct packed {
    logic [MAG_W-1:0] value;
    logic [IDX_W-1:0] offset;
    logic             conv;
  } result_t;

endpackage

// File: rtl/core/ssp_decode.sv
// Byte classifier: white space, sign, prefix letters and digit value.
// Depends on ssp_pkg.
module ssp_decode (
  input  logic [7:0]          char_code,
  output ssp_pkg::char_class_t cls
);
  import ssp_pkg::*;

  always_comb begin
    cls.is_nul   = (char_code == 8'd0);
    cls.is_space = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
    cls.is_plus  = (char_code == 8'h2B);
    cls.is_minus = (char_code == 8'h2D);
    cls.is_zero  = (char_code == 8'h30);
    cls.is_x     = (char_code == 8'h78) || (char_code == 8'h58);
    // Map 0-9, a-z, A-Z to 0..35; anything else is no digit
    if (char_code >= 8'h30 && char_code <= 8'h39) begin
      cls.digit = BASE_W'(char_code - 8'h30);
    end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
      cls.digit = BASE_W'(char_code - 8'h61 + 8'd10);
    end else if (char_code >= 8'h41 && char_code <= 8'h5A) begin
      cls.digit = BASE_W'(char_code - 8'h41 + 8'd10);
    end else begin
      cls.digit = NO_DIGIT;
    end
  end

endmodule

// File: rtl/core/ssp_parse.sv
// Parser state and one-byte step: phase, sign, base, magnitude, offset.
// Depends on ssp_pkg; fed by ssp_decode through the top level.
module ssp_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  ssp_pkg::char_class_t      cls,
  input  logic [ssp_pkg::BASE_W-1:0] number_base,
  output ssp_pkg::result_t          res
);
  import ssp_pkg::*;

  phase_t             phase, phase_next;
  logic               negative, negative_next;
  logic [BASE_W-1:0]  active_base, active_base_next;
  logic [MAG_W-1:0]   magnitude, magnitude_next;
  logic               any_digit, any_digit_next;
  logic [IDX_W-1:0]   char_index, char_index_next;

  logic               do_digit, over, bump, dec, sign_zero;
  logic [BASE_W-1:0]  sel_base;
  logic [PROD_W-1:0]  prod, cutoff;
  logic [IDX_W-1:0]   end_idx;

  // Multiply-add for the digit path
  assign cutoff = negative ? PROD_W'(33'h080000000) : PROD_W'(33'h07FFFFFFF);
  assign prod   = PROD_W'(magnitude) * PROD_W'(active_base_next) + PROD_W'(cls.digit);

  // Result seen at the zero byte
  always_comb begin
    end_idx = char_index;
    if (phase == PH_AFTERX && char_index != '0) begin
      end_idx = char_index - IDX_W'(1);
    end
    res.conv   = any_digit;
    res.offset = any_digit ? end_idx : '0;
    res.value  = any_digit ? (negative ? MAG_W'(0) - magnitude : magnitude) : '0;
  end

  // Next state for one byte
  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    active_base_next = active_base;
    magnitude_next   = magnitude;
    any_digit_next   = any_digit;
    do_digit         = 1'b0;
    over             = 1'b0;
    bump             = 1'b0;
    dec              = 1'b0;
    sel_base         = (phase == PH_SPACE) ? number_base : active_base;
    sign_zero        = (sel_base == BASE_AUTO || sel_base == BASE_HEX) && cls.is_zero;

    case (phase)
      PH_SPACE, PH_SIGN: begin
        if (phase == PH_SPACE && cls.is_space) begin
          bump = 1'b1;
        end else if (phase == PH_SPACE &&
                     (number_base == BASE_W'(1) || number_base > BASE_MAX)) begin
          phase_next = PH_STOP;
        end else if (phase == PH_SPACE && (cls.is_plus || cls.is_minus)) begin
          active_base_next = number_base;
          negative_next    = cls.is_minus;
          bump             = 1'b1;
          phase_next       = PH_SIGN;
        end else if (sign_zero) begin
          active_base_next = sel_base;
          any_digit_next   = 1'b1;
          magnitude_next   = '0;
          bump             = 1'b1;
          phase_next       = PH_PREFIX;
        end else begin
          active_base_next = (sel_base == BASE_AUTO) ? BASE_DEC : sel_base;
          phase_next       = PH_DIGITS;
          do_digit         = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (cls.is_x) begin
          active_base_next = BASE_HEX;
          bump             = 1'b1;
          phase_next       = PH_AFTERX;
        end else begin
          active_base_next = (active_base == BASE_AUTO) ? BASE_OCT : active_base;
          phase_next       = PH_DIGITS;
          do_digit         = 1'b1;
        end
      end
      PH_AFTERX: begin
        if (cls.digit < BASE_HEX) begin
          phase_next = PH_DIGITS;
          do_digit   = 1'b1;
        end else begin
          dec        = (char_index != '0);
          phase_next = PH_STOP;
        end
      end
      PH_DIGITS, PH_OVER: begin
        over     = (phase == PH_OVER);
        do_digit = 1'b1;
      end
      default: begin
      end
    endcase

    // Accumulate one digit, saturate on overflow, stop on a non-digit
    if (do_digit) begin
      if (cls.digit >= active_base_next) begin
        phase_next = PH_STOP;
      end else if (over) begin
        bump = 1'b1;
      end else begin
        if (prod > cutoff) begin
          magnitude_next = MAG_W'(cutoff);
          phase_next     = PH_OVER;
        end else begin
          magnitude_next = MAG_W'(prod);
        end
        any_digit_next = 1'b1;
        bump           = 1'b1;
      end
    end

    // Saturating offset counter
    char_index_next = char_index;
    if (bump && char_index < IDX_W'(MAX_LENGTH)) begin
      char_index_next = char_index + IDX_W'(1);
    end else if (dec) begin
      char_index_next = char_index - IDX_W'(1);
    end
  end

  // State registers; rearm at the zero byte
  always_ff @(posedge clk) begin
    if (rst || (step && cls.is_nul)) begin
      phase       <= PH_SPACE;
      negative    <= 1'b0;
      active_base <= '0;
      magnitude   <= '0;
      any_digit   <= 1'b0;
      char_index  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      negative    <= negative_next;
      active_base <= active_base_next;
      magnitude   <= magnitude_next;
      any_digit   <= any_digit_next;
      char_index  <= char_index_next;
    end
  end

endmodule

// File: rtl/core/string_to_signed_parser.sv
// Top level of the streaming string-to-signed-integer parser.
// Depends on ssp_pkg, ssp_decode, ssp_parse and string_to_signed_parser_assert.svh.
`include "string_to_signed_parser_assert.svh"

// Streaming strtol for 32-bit signed results. Send a string one byte per
// beat, ended by a zero byte; the zero byte produces one result beat with the
// saturated value, the end offset and the converted flag, and the parser then
// rearms for the next string. The block takes one byte per cycle unless in_stall
// is high: each byte goes from the input register through one 32x6 multiply-add
// and compare into the parser state, and a result reaches the output register
// as its zero byte leaves the input register. Non-zero bytes keep flowing
// while a result waits on the output; only a zero byte waits for the output
// register to free up. Write number_base only while no string is in flight;
// it is sampled at the first byte of a string that is not white space.
module string_to_signed_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ssp_pkg::BASE_W-1:0] number_base,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 char_code,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         parsed_value,
  output logic [ssp_pkg::IDX_W-1:0]  end_offset,
  output logic                       converted
);
  import ssp_pkg::*;

  logic [BASE_W-1:0] base_reg;
  logic              r_valid;
  logic [7:0]        r_char;
  logic              out_free, proc_fire;
  char_class_t       cls;
  result_t           res;

  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_reg <= number_base;
    end
  end

  // Handshake: a zero byte needs a free output register
  assign out_free  = !out_valid || !out_stall;
  assign proc_fire = r_valid && (!cls.is_nul || out_free);
  assign in_stall  = r_valid && !proc_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!in_stall) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      r_char <= char_code;
    end
  end

  ssp_decode u_decode (
    .char_code (r_char),
    .cls       (cls)
  );

  ssp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (proc_fire),
    .cls         (cls),
    .number_base (base_reg),
    .res         (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= proc_fire && cls.is_nul;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && proc_fire && cls.is_nul) begin
      parsed_value <= res.value;
      end_offset   <= res.offset;
      converted    <= res.conv;
    end
  end

  // Checks
  `SSP_ASSERT_IMPLY(a_stall_needs_item, in_stall, r_valid && cls.is_nul)
  `SSP_ASSERT_NEXT(a_result_from_nul, out_free && proc_fire && cls.is_nul, out_valid)
  `SSP_ASSERT_IMPLY(a_unconverted_zero, out_valid && !converted, {parsed_value, end_offset} == '0)
  `SSP_ASSERT_IMPLY(a_offset_bound, out_valid, end_offset <= IDX_W'(MAX_LENGTH))

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for string_to_signed_parser: streams strings byte by byte,
// predicts each result with a behavioral parser model and compares every result beat.
// Depends on ssp_pkg and the string_to_signed_parser RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssp_pkg::*;

  localparam logic [BASE_W-1:0] BASE_ONE = BASE_W'(1);

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [BASE_W-1:0]        number_base;
  logic                     in_valid;
  logic                     in_stall;
  logic [7:0]               char_code;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [31:0]       parsed_value;
  logic [IDX_W-1:0]         end_offset;
  logic                     converted;

  // Parser model state
  logic [BASE_W-1:0]        base_reg;
  phase_t                   scan_phase;
  logic                     neg;
  logic [BASE_W-1:0]        work_base;
  logic [MAG_W-1:0]         mag;
  logic                     seen_digit;
  logic [IDX_W-1:0]         char_pos;

  result_t                  pending_numbers[$];
  int                       mismatch_count;
  bit                       quiet;

  string_to_signed_parser dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .number_base  (number_base),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .parsed_value (parsed_value),
    .end_offset   (end_offset),
    .converted    (converted)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  function automatic void rearm_parser();
    scan_phase = PH_SPACE;
    neg        = 1'b0;
    work_base  = '0;
    mag        = '0;
    seen_digit = 1'b0;
    char_pos   = '0;
  endfunction

  // Saturating count of consumed bytes
  function automatic void advance_pos();
    if (char_pos < MAX_LENGTH) char_pos = char_pos + 1'b1;
  endfunction

  function automatic logic [BASE_W-1:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return BASE_W'(c - "0");
    if (c >= "a" && c <= "z") return BASE_W'(c - "a" + 8'd10);
    if (c >= "A" && c <= "Z") return BASE_W'(c - "A" + 8'd10);
    return NO_DIGIT;
  endfunction

  // Multiply-accumulate one digit, saturating at the signed limit
  function automatic void accum_digit(input logic [7:0] c);
    logic [BASE_W-1:0] d;
    logic [39:0]       t;
    logic [39:0]       limit;
    d = digit_value(c);
    if (d >= work_base) begin
      scan_phase = PH_STOP;
      return;
    end
    if (scan_phase == PH_OVER) begin
      advance_pos();
      return;
    end
    limit = neg ? 40'h8000_0000 : 40'h7FFF_FFFF;
    t = 40'(mag) * 40'(work_base) + 40'(d);
    if (t > limit) begin
      mag        = limit[MAG_W-1:0];
      scan_phase = PH_OVER;
    end else begin
      mag = t[MAG_W-1:0];
    end
    seen_digit = 1'b1;
    advance_pos();
  endfunction

  // First byte after white space and sign: a '0' may open a prefix
  function automatic void after_sign(input logic [7:0] c);
    if ((work_base == BASE_AUTO || work_base == BASE_HEX) && c == "0") begin
      seen_digit = 1'b1;
      mag        = '0;
      advance_pos();
      scan_phase = PH_PREFIX;
      return;
    end
    if (work_base == BASE_AUTO) work_base = BASE_DEC;
    scan_phase = PH_DIGITS;
    accum_digit(c);
  endfunction

  // Advance the model by one byte; a zero byte queues the expected result
  function automatic void parse_byte(input logic [7:0] c);
    result_t          r;
    logic [IDX_W-1:0] stop_at;
    if (c == 8'd0) begin
      stop_at = char_pos;
      if (scan_phase == PH_AFTERX && stop_at > 0) stop_at = stop_at - 1'b1;
      r.value  = !seen_digit ? '0 : (neg ? 32'd0 - mag : mag);
      r.offset = seen_digit ? stop_at : '0;
      r.conv   = seen_digit;
      pending_numbers.push_back(r);
      rearm_parser();
      return;
    end
    case (scan_phase)
      PH_SPACE: begin
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
          advance_pos();
        end else if (base_reg == BASE_ONE || base_reg > BASE_MAX) begin
          scan_phase = PH_STOP;
        end else begin
          work_base = base_reg;
          if (c == "+" || c == "-") begin
            neg = (c == "-");
            advance_pos();
            scan_phase = PH_SIGN;
          end else begin
            after_sign(c);
          end
        end
      end
      PH_SIGN: after_sign(c);
      PH_PREFIX: begin
        if (c == "x" || c == "X") begin
          work_base = BASE_HEX;
          advance_pos();
          scan_phase = PH_AFTERX;
        end else begin
          if (work_base == BASE_AUTO) work_base = BASE_OCT;
          scan_phase = PH_DIGITS;
          accum_digit(c);
        end
      end
      PH_AFTERX: begin
        if (digit_value(c) < BASE_HEX) begin
          scan_phase = PH_DIGITS;
          accum_digit(c);
        end else begin
          if (char_pos > 0) char_pos = char_pos - 1'b1;
          scan_phase = PH_STOP;
        end
      end
      PH_DIGITS, PH_OVER: accum_digit(c);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Send one byte, with an occasional idle burst ahead of it
  task automatic send_char(input logic [7:0] c);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    parse_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(8'd0);
  endtask

  // Drop valid and wait until every result is back and the pipeline drained
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] b);
    settle();
    cfg_valid   <= 1'b1;
    number_base <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    base_reg = b;
  endtask

  // Random stall bursts on the result side
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest expected number
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_numbers.size() == 0) begin
        report_mismatch("result beat with no string pending");
      end else begin
        want = pending_numbers.pop_front();
        if (parsed_value !== want.value)
          report_mismatch($sformatf("parsed_value %0d, expected %0d",
                                    parsed_value, $signed(want.value)));
        if (end_offset !== want.offset)
          report_mismatch($sformatf("end_offset %0d, expected %0d",
                                    end_offset, want.offset));
        if (converted !== want.conv)
          report_mismatch($sformatf("converted %b, expected %b", converted, want.conv));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic string noise_byte();
    return $sformatf("%c", 8'($urandom_range(1, 255)));
  endfunction

  // Mostly well-formed numbers for the given base, some noise and junk tails
  function automatic string random_number(input logic [BASE_W-1:0] b);
    string      s;
    int         radix;
    int         ndig;
    int         d;
    logic [7:0] c;
    s = "";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 8)) s = {s, noise_byte()};
      return s;
    end
    repeat ($urandom_range(0, 2))
      case ($urandom_range(0, 5))
        0:       s = {s, " "};
        1:       s = {s, "\t"};
        2:       s = {s, "\n"};
        3:       s = {s, "\013"};
        4:       s = {s, "\014"};
        default: s = {s, "\r"};
      endcase
    case ($urandom_range(0, 2))
      1:       s = {s, "+"};
      2:       s = {s, "-"};
      default: ;
    endcase
    radix = (b == BASE_AUTO || b == BASE_ONE || b > BASE_MAX) ? 10 : int'(b);
    if (b == BASE_AUTO || b == BASE_HEX) begin
      case ($urandom_range(0, 3))
        0: begin s = {s, "0x"}; radix = 16; end
        1: begin s = {s, "0X"}; radix = 16; end
        2: if (b == BASE_AUTO) begin s = {s, "0"}; radix = 8; end
        default: ;
      endcase
    end
    ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    repeat (ndig) begin
      d = $urandom_range(0, radix - 1);
      if (d < 10) c = 8'("0" + d);
      else        c = 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
      s = {s, $sformatf("%c", c)};
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) s = {s, noise_byte()};
    return s;
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    case ($urandom_range(0, 7))
      0:       return BASE_AUTO;
      1:       return BASE_HEX;
      2:       return BASE_DEC;
      3:       return BASE_OCT;
      4:       return BASE_W'(2);
      5:       return BASE_MAX;
      6:       return BASE_W'($urandom_range(2, 36));
      default: return BASE_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Decimal at the reset base: limits, overflow, white space, signs, odd bytes
  task automatic test_decimal_limits();
    send_text("2147483647");
    send_text("-2147483648");
    send_text("2147483648");
    send_text("-99999999999999x");
    send_text(" \t\n\013\014\r+42abc");
    send_text("");
    send_text("   ");
    send_text("-");
    send_text("\377\200");
  endtask

  // Base 0 prefix detection and bare "0x"
  task automatic test_auto_prefix();
    write_base(BASE_AUTO);
    send_text("0x1F");
    send_text("0X");
    send_text("0xg");
    send_text("0789");
    send_text("-0x80000000");
    send_text("123");
  endtask

  task automatic test_hex_prefix();
    write_base(BASE_HEX);
    send_text("0xFFFFFFFF");
    send_text("-ff");
    send_text("0xg");
  endtask

  // Smallest and largest radix, then bases that convert nothing
  task automatic test_base_extremes();
    write_base(BASE_W'(2));
    send_text("-1012");
    send_text("111111111111111111111111111111111");
    write_base(BASE_MAX);
    send_text("zZ");
    send_text("-zzzzzzzz");
    write_base(BASE_ONE);
    send_text("123");
    write_base(BASE_W'(63));
    send_text(" 5");
  endtask

  // Offset counting over long runs of white space and leading zeros
  task automatic test_long_string();
    string s;
    write_base(BASE_DEC);
    s = "";
    repeat (40) s = {s, " "};
    send_text({s, "12"});
    s = "";
    repeat (40) s = {s, "0"};
    send_text({s, "9"});
  endtask

  task automatic test_random_strings();
    int                chars;
    int                strings;
    logic [BASE_W-1:0] b;
    string             s;
    chars   = 0;
    strings = 0;
    while (chars < 60 || strings < 6) begin
      b = random_base();
      write_base(b);
      repeat ($urandom_range(4, 10)) begin
        s = random_number(b);
        send_text(s);
        chars += s.len() + 1;
        strings++;
      end
    end
  endtask

  // Full rate on both sides for the tail of the run
  task automatic test_back_to_back();
    quiet = 1'b1;
    write_base(BASE_AUTO);
    repeat (8) send_text(random_number(BASE_AUTO));
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    number_base <= BASE_RESET;
    in_valid    <= 1'b0;
    char_code   <= 8'd0;
    quiet          = 1'b0;
    mismatch_count = 0;
    base_reg       = BASE_RESET;
    rearm_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_decimal_limits();
    test_auto_prefix();
    test_hex_prefix();
    test_base_extremes();
    test_long_string();
    test_random_strings();
    test_back_to_back();

    settle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
